// File: design/lbb_pkg.sv
package lbb_pkg;

    localparam int LABEL_COUNT_DEF = 256;
    localparam int COORD_BITS_DEF = 10;

    localparam int LABEL_W = 12;
    localparam int COORD_W = 10;
    localparam int TOP_W = 8;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               present;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_z;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_z;
        logic [TOP_W-1:0]   top;
        logic               overflow;
    } result_t;

endpackage

// File: design/label_bounding_box_table.sv
// Bounding box table for labelled voxels. Each input word is either a voxel
// update or a query; only queries produce an output word. The block sustains
// one input word per clock while the output queue has room: the per-label
// boxes live in a single synchronous memory that is read when a word is
// accepted and written back on the next cycle, with a one-entry bypass so that
// consecutive voxels of the same label see each other's update. A query's
// result enters a two-word output queue in the cycle after the query is
// accepted. After reset the block sweeps the memory to clear every seen mark,
// one entry per cycle, and holds in_ready low while it does so.
module label_bounding_box_table
    import lbb_pkg::*;
#(
    parameter int LABEL_COUNT = LABEL_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [LABEL_W-1:0] voxel_label,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [COORD_W-1:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               label_present,
    output logic [COORD_W-1:0] min_x,
    output logic [COORD_W-1:0] min_y,
    output logic [COORD_W-1:0] min_z,
    output logic [COORD_W-1:0] max_x,
    output logic [COORD_W-1:0] max_y,
    output logic [COORD_W-1:0] max_z,
    output logic [TOP_W-1:0]   highest_label_seen,
    output logic               label_overflow
);

    localparam int LW = $clog2(LABEL_COUNT);
    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int WW = 1 + 6 * CW;
    localparam logic [LW-1:0] LAST_IDX = LW'(LABEL_COUNT - 1);
    localparam logic [LABEL_W:0] COUNT_EXT = (LABEL_W + 1)'(LABEL_COUNT);

    logic          clr_active_reg;
    logic [LW-1:0] clr_idx_reg;

    logic               s1_valid_reg;
    logic               s1_query_reg;
    logic [LABEL_W-1:0] s1_label_reg;
    logic [CW-1:0]      s1_pos_reg [3];

    logic          fwd_valid_reg;
    logic [LW-1:0] fwd_addr_reg;
    logic [WW-1:0] fwd_data_reg;

    logic [LW-1:0] top_label_reg;
    logic [LW-1:0] top_label_next;
    logic          overflow_reg;
    logic          overflow_next;

    result_t    q_reg [2];
    logic       q_wr_ptr_reg;
    logic       q_rd_ptr_reg;
    logic [1:0] q_cnt_reg;
    logic [1:0] q_cnt_after;

    logic          accept;
    logic          push;
    logic          pop;
    logic [LW-1:0] s1_addr;
    logic          s1_in_table;
    logic          s1_write;
    logic [WW-1:0] rd_word;
    logic [WW-1:0] cur_word;
    logic [WW-1:0] new_word;
    logic          cur_seen;
    logic [CW-1:0] cur_lo [3];
    logic [CW-1:0] cur_hi [3];
    logic          ram_wr_en;
    logic [LW-1:0] ram_wr_addr;
    logic [WW-1:0] ram_wr_data;
    logic [LABEL_W-1:0] top_ext;
    result_t       result;

    lbb_ram #(
        .DEPTH(LABEL_COUNT),
        .WIDTH(WW)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(voxel_label[LW-1:0]),
        .rd_data(rd_word)
    );

    assign pop = out_valid && out_ready;
    assign push = s1_valid_reg && (s1_query_reg == REQ_QUERY);
    assign q_cnt_after = q_cnt_reg - {1'b0, pop};
    assign in_ready = !clr_active_reg &&
                      ((q_cnt_after == 2'd0) || ((q_cnt_after == 2'd1) && !push));
    assign accept = in_valid && in_ready;

    assign s1_addr = s1_label_reg[LW-1:0];
    assign s1_in_table = (s1_label_reg != '0) && ({1'b0, s1_label_reg} < COUNT_EXT);
    assign s1_write = s1_valid_reg && (s1_query_reg == REQ_UPDATE) && s1_in_table;

    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : rd_word;
    assign cur_seen = cur_word[WW-1];

    always_comb
    begin
        new_word = '0;
        new_word[WW-1] = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            cur_lo[a] = cur_word[(5 - a) * CW +: CW];
            cur_hi[a] = cur_word[(2 - a) * CW +: CW];
            new_word[(5 - a) * CW +: CW] =
                (!cur_seen || (s1_pos_reg[a] < cur_lo[a])) ? s1_pos_reg[a] : cur_lo[a];
            new_word[(2 - a) * CW +: CW] =
                (!cur_seen || (s1_pos_reg[a] > cur_hi[a])) ? s1_pos_reg[a] : cur_hi[a];
        end
    end

    always_comb
    begin
        top_label_next = top_label_reg;
        overflow_next = overflow_reg;
        if (s1_valid_reg && (s1_query_reg == REQ_UPDATE) && (s1_label_reg != '0))
        begin
            if (!s1_in_table)
            begin
                overflow_next = 1'b1;
            end
            else if (s1_addr > top_label_reg)
            begin
                top_label_next = s1_addr;
            end
        end
    end

    assign ram_wr_en = clr_active_reg || s1_write;
    assign ram_wr_addr = clr_active_reg ? clr_idx_reg : s1_addr;
    assign ram_wr_data = clr_active_reg ? '0 : new_word;

    assign top_ext = LABEL_W'(top_label_reg);

    always_comb
    begin
        result.present = s1_in_table && cur_seen;
        result.min_x = result.present ? COORD_W'(cur_lo[0]) : '0;
        result.min_y = result.present ? COORD_W'(cur_lo[1]) : '0;
        result.min_z = result.present ? COORD_W'(cur_lo[2]) : '0;
        result.max_x = result.present ? COORD_W'(cur_hi[0]) : '0;
        result.max_y = result.present ? COORD_W'(cur_hi[1]) : '0;
        result.max_z = result.present ? COORD_W'(cur_hi[2]) : '0;
        result.top = top_ext[TOP_W-1:0];
        result.overflow = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            top_label_reg <= '0;
            overflow_reg <= 1'b0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            s1_valid_reg <= accept;
            fwd_valid_reg <= s1_write;
            top_label_reg <= top_label_next;
            overflow_reg <= overflow_next;
            if (push)
            begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
            q_cnt_reg <= q_cnt_after + {1'b0, push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_query_reg <= req_type;
            s1_label_reg <= voxel_label;
            s1_pos_reg[0] <= coord_x[CW-1:0];
            s1_pos_reg[1] <= coord_y[CW-1:0];
            s1_pos_reg[2] <= coord_z[CW-1:0];
        end
        fwd_addr_reg <= s1_addr;
        fwd_data_reg <= new_word;
        if (push)
        begin
            q_reg[q_wr_ptr_reg] <= result;
        end
    end

    assign out_valid = (q_cnt_reg != 2'd0);
    assign label_present = q_reg[q_rd_ptr_reg].present;
    assign min_x = q_reg[q_rd_ptr_reg].min_x;
    assign min_y = q_reg[q_rd_ptr_reg].min_y;
    assign min_z = q_reg[q_rd_ptr_reg].min_z;
    assign max_x = q_reg[q_rd_ptr_reg].max_x;
    assign max_y = q_reg[q_rd_ptr_reg].max_y;
    assign max_z = q_reg[q_rd_ptr_reg].max_z;
    assign highest_label_seen = q_reg[q_rd_ptr_reg].top;
    assign label_overflow = q_reg[q_rd_ptr_reg].overflow;

endmodule

// File: design/lbb_ram.sv
module lbb_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 31
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
